// ===== hw/rtl/range_frame_xor_parser_defines.svh =====
// Assertion macros shared by the range frame parser RTL.
`ifndef RANGE_FRAME_XOR_PARSER_DEFINES_SVH
`define RANGE_FRAME_XOR_PARSER_DEFINES_SVH

// Checked on every rising edge of clk, ignored while reset is asserted.
`define RFXP_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Checked on every rising edge of clk, reset included.
`define RFXP_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== hw/rtl/rfxp_pkg.sv =====
package rfxp_pkg;

  localparam logic [7:0] FRAME_HEADER = 8'hAB;
  localparam int         FRAME_LEN    = 17;
  localparam int         POS_W        = $clog2(FRAME_LEN);
  localparam int         DIST_W       = 16;

  // Position of the check byte, the last byte of a frame.
  localparam logic [POS_W-1:0] CHECK_POS = POS_W'(FRAME_LEN - 1);

  // Frame positions of the captured distance bytes.
  localparam logic [POS_W-1:0] POS_FIRST_HI = POS_W'(4);
  localparam logic [POS_W-1:0] POS_FIRST_LO = POS_W'(5);
  localparam logic [POS_W-1:0] POS_PEAK_HI  = POS_W'(8);
  localparam logic [POS_W-1:0] POS_PEAK_LO  = POS_W'(9);
  localparam logic [POS_W-1:0] POS_LAST_HI  = POS_W'(12);
  localparam logic [POS_W-1:0] POS_LAST_LO  = POS_W'(13);

  typedef struct packed {
    logic [DIST_W-1:0] first_distance;
    logic [DIST_W-1:0] peak_distance;
    logic [DIST_W-1:0] last_distance;
  } dist_t;

endpackage

// ===== hw/rtl/rfxp_frame.sv =====
`include "range_frame_xor_parser_defines.svh"

module rfxp_frame
  import rfxp_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       step,
  input  logic [7:0] rx_byte,
  output logic       frame_good,
  output dist_t      dists
);

  logic [POS_W-1:0] pos_r, pos_nxt;
  logic [7:0]       xor_r, xor_nxt;
  logic [7:0]       first_hi_r, first_lo_r;
  logic [7:0]       peak_hi_r, peak_lo_r;
  logic [7:0]       last_hi_r, last_lo_r;
  logic             at_start, at_check;

  assign at_start = (pos_r == '0);
  // Anything at or beyond the check position is handled as the check byte.
  assign at_check = (pos_r >= CHECK_POS);

  assign frame_good = at_check && (xor_r == rx_byte);

  always_comb begin
    pos_nxt = pos_r;
    xor_nxt = xor_r;
    if (at_start) begin
      if (rx_byte == FRAME_HEADER) begin
        pos_nxt = POS_W'(1);
        xor_nxt = rx_byte;
      end
    end else if (at_check) begin
      pos_nxt = '0;
      xor_nxt = '0;
    end else begin
      pos_nxt = pos_r + POS_W'(1);
      xor_nxt = xor_r ^ rx_byte;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r <= '0;
      xor_r <= '0;
    end else if (step) begin
      pos_r <= pos_nxt;
      xor_r <= xor_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      unique case (pos_r)
        POS_FIRST_HI: first_hi_r <= rx_byte;
        POS_FIRST_LO: first_lo_r <= rx_byte;
        POS_PEAK_HI:  peak_hi_r  <= rx_byte;
        POS_PEAK_LO:  peak_lo_r  <= rx_byte;
        POS_LAST_HI:  last_hi_r  <= rx_byte;
        POS_LAST_LO:  last_lo_r  <= rx_byte;
        default: ;
      endcase
    end
  end

  assign dists.first_distance = {first_hi_r, first_lo_r};
  assign dists.peak_distance  = {peak_hi_r, peak_lo_r};
  assign dists.last_distance  = {last_hi_r, last_lo_r};

  `RFXP_ASSERT(a_pos_range, pos_r <= CHECK_POS, "frame position beyond check byte")
  `RFXP_ASSERT(a_check_restart, step && at_check |=> pos_r == '0 && xor_r == '0,
               "parser did not restart after the check byte")
  `RFXP_ASSERT(a_hunt_holds, step && at_start && rx_byte != FRAME_HEADER |=> pos_r == '0,
               "non-header byte started a frame")

endmodule

// ===== hw/rtl/range_frame_xor_parser.sv =====
// A result is offered after its check byte has passed the input register
// and then the result register, which it enters once that register is free.
// Throughput: one byte per cycle; the input stalls only when a good frame
// completes while the previous result still waits in the result register.
// Reset (rst_n, synchronous, active low) empties both registers and restarts
// the hunt for a header byte.
`include "range_frame_xor_parser_defines.svh"

module range_frame_xor_parser
  import rfxp_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [7:0]        in_rx_byte,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [DIST_W-1:0] out_first_distance,
  output logic [DIST_W-1:0] out_peak_distance,
  output logic [DIST_W-1:0] out_last_distance
);

  logic       s1_valid_r;
  logic [7:0] s1_byte_r;
  logic       s1_fire;
  logic       frame_good;
  logic       out_free;
  logic       out_valid_r;
  dist_t      frame_dists;
  dist_t      out_r;

  rfxp_frame u_frame (
    .clk        (clk),
    .rst_n      (rst_n),
    .step       (s1_fire),
    .rx_byte    (s1_byte_r),
    .frame_good (frame_good),
    .dists      (frame_dists)
  );

  assign out_free = !out_valid_r || out_ready;
  // A byte that produces no result never waits for the output side.
  assign s1_fire  = s1_valid_r && (!frame_good || out_free);
  assign in_ready = !s1_valid_r || s1_fire;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (in_ready) begin
        s1_valid_r <= in_valid;
      end
      if (s1_fire && frame_good) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1_byte_r <= in_rx_byte;
    end
    if (s1_fire && frame_good) begin
      out_r <= frame_dists;
    end
  end

  assign out_valid          = out_valid_r;
  assign out_first_distance = out_r.first_distance;
  assign out_peak_distance  = out_r.peak_distance;
  assign out_last_distance  = out_r.last_distance;

  `RFXP_ASSERT(a_result_loaded, s1_fire && frame_good |=> out_valid_r,
               "good frame did not produce a result")
  `RFXP_ASSERT(a_no_overwrite, out_valid_r && !out_ready && frame_good |-> !s1_fire,
               "waiting result overwritten")
  `RFXP_ASSERT_ALWAYS(a_reset_empty, !rst_n |=> !s1_valid_r && !out_valid_r,
                      "pipeline not empty after reset")

endmodule

// ===== bench/tb.sv =====
module tb;
  import rfxp_pkg::*;

  typedef logic [7:0] frame_t [FRAME_LEN];

  // One directed frame: an optional leading byte, the frame itself, and
  // where it is obvious, the distances that the frame must produce.
  typedef struct {
    bit         has_lead;
    logic [7:0] lead;
    dist_t      dists;
    logic [7:0] fill;
    bit         corrupt;
    bit         typed;
    dist_t      want;
  } frame_row_t;

  logic              clk;
  logic              rst_n = 1'b0;
  logic              in_valid = 1'b0;
  logic              in_ready;
  logic [7:0]        in_rx_byte = 8'h00;
  logic              out_valid;
  logic              out_ready = 1'b0;
  logic [DIST_W-1:0] out_first_distance;
  logic [DIST_W-1:0] out_peak_distance;
  logic [DIST_W-1:0] out_last_distance;

  // Predictor state: a copy of the parser's frame position, XOR and captures.
  logic [4:0] frame_pos;
  logic [7:0] frame_xor;
  logic [7:0] dist_bytes [6];

  dist_t      pending_dists [$];
  int         errors = 0;
  int         bytes_sent = 0;
  bit         idle_en = 1'b1;
  int         tx_idle_pct = 10;
  bit         hold_req = 1'b0;
  frame_row_t rows [3];

  range_frame_xor_parser DUT (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_ready           (in_ready),
    .in_rx_byte         (in_rx_byte),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .out_first_distance (out_first_distance),
    .out_peak_distance  (out_peak_distance),
    .out_last_distance  (out_last_distance)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  initial begin
    #1000000;
    $display("Some tests failed");
    $finish;
  end

  // Takes one accepted byte; returns 1 with the distances when a good frame ends.
  function automatic bit parse_byte(input logic [7:0] b, output dist_t d);
    bit good;
    d = '0;
    if (frame_pos == '0) begin
      if (b == FRAME_HEADER) begin
        frame_xor = b;
        frame_pos = 5'd1;
      end
      return 1'b0;
    end
    if (frame_pos < 5'(CHECK_POS)) begin
      case (frame_pos)
        5'(POS_FIRST_HI): dist_bytes[0] = b;
        5'(POS_FIRST_LO): dist_bytes[1] = b;
        5'(POS_PEAK_HI):  dist_bytes[2] = b;
        5'(POS_PEAK_LO):  dist_bytes[3] = b;
        5'(POS_LAST_HI):  dist_bytes[4] = b;
        5'(POS_LAST_LO):  dist_bytes[5] = b;
        default: ;
      endcase
      frame_xor = frame_xor ^ b;
      frame_pos = frame_pos + 5'd1;
      return 1'b0;
    end
    good = (frame_xor == b);
    frame_pos = '0;
    frame_xor = '0;
    if (good) begin
      d.first_distance = {dist_bytes[0], dist_bytes[1]};
      d.peak_distance  = {dist_bytes[2], dist_bytes[3]};
      d.last_distance  = {dist_bytes[4], dist_bytes[5]};
    end
    return good;
  endfunction

  function automatic frame_t build_frame(input dist_t d, input logic [7:0] fill,
                                         input bit rand_fill, input bit corrupt);
    frame_t     f;
    logic [7:0] sum;
    f[0] = FRAME_HEADER;
    for (int i = 1; i < FRAME_LEN - 1; i++) f[i] = rand_fill ? 8'($urandom) : fill;
    f[POS_FIRST_HI] = d.first_distance[15:8];
    f[POS_FIRST_LO] = d.first_distance[7:0];
    f[POS_PEAK_HI]  = d.peak_distance[15:8];
    f[POS_PEAK_LO]  = d.peak_distance[7:0];
    f[POS_LAST_HI]  = d.last_distance[15:8];
    f[POS_LAST_LO]  = d.last_distance[7:0];
    sum = '0;
    for (int i = 0; i < FRAME_LEN - 1; i++) sum = sum ^ f[i];
    f[CHECK_POS] = corrupt ? sum ^ 8'($urandom_range(1, 255)) : sum;
    return f;
  endfunction

  function automatic logic [15:0] pick_distance();
    case ($urandom_range(0, 7))
      0: return 16'h0000;
      1: return 16'hFFFF;
      default: return 16'($urandom);
    endcase
  endfunction

  task automatic note_failure(input string msg);
    if (errors < 10) $display("ERROR at %0t: %s", $time, msg);
    errors++;
  endtask

  // Offers one byte and waits until it is taken; the prediction is made at
  // the accepting edge.
  task automatic send_byte(input logic [7:0] b, input bit use_typed, input dist_t want);
    dist_t pred;
    bit    got;
    if (idle_en && $urandom_range(0, 99) < tx_idle_pct) begin
      @(negedge clk);
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 17) - 1) @(negedge clk);
    end
    @(negedge clk);
    in_valid   <= 1'b1;
    in_rx_byte <= b;
    do @(posedge clk); while (!in_ready);
    got = parse_byte(b, pred);
    if (use_typed) pending_dists.push_back(want);
    else if (got) pending_dists.push_back(pred);
    bytes_sent++;
  endtask

  task automatic send_frame(input frame_t f, input int count, input bit use_typed,
                            input dist_t want);
    for (int i = 0; i < count; i++) send_byte(f[i], use_typed && i == FRAME_LEN - 1, want);
  endtask

  // Lowers valid and waits until every expected result has come out.
  task automatic drain();
    @(negedge clk);
    in_valid <= 1'b0;
    while (pending_dists.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // Receiver: random stall bursts, one long hold-off on request.
  initial begin
    forever begin
      @(negedge clk);
      if (hold_req) begin
        out_ready <= 1'b0;
        repeat (299) @(negedge clk);
        hold_req = 1'b0;
      end else if (idle_en && $urandom_range(0, 7) == 0) begin
        out_ready <= 1'b0;
        repeat ($urandom_range(1, 17) - 1) @(negedge clk);
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin : check_results
    dist_t exp_d;
    if (rst_n && out_valid && out_ready) begin
      if (pending_dists.size() == 0) begin
        note_failure($sformatf("unexpected result %h %h %h", out_first_distance,
                               out_peak_distance, out_last_distance));
      end else begin
        exp_d = pending_dists.pop_front();
        if (out_first_distance !== exp_d.first_distance ||
            out_peak_distance  !== exp_d.peak_distance  ||
            out_last_distance  !== exp_d.last_distance)
          note_failure($sformatf("expected %h %h %h, got %h %h %h",
                                 exp_d.first_distance, exp_d.peak_distance,
                                 exp_d.last_distance, out_first_distance,
                                 out_peak_distance, out_last_distance));
      end
    end
  end

  initial begin
    frame_t f;
    dist_t  d;
    int     kind;
    int     n;
    bit     held = 1'b0;
    bit     paused = 1'b0;

    frame_pos = '0;
    frame_xor = '0;
    foreach (dist_bytes[i]) dist_bytes[i] = '0;

    // All-zero frame after a discarded zero byte; all-ones frame with the
    // header value used as filler; a frame with a wrong check byte.
    rows[0] = '{1'b1, 8'h00, 48'h0000_0000_0000, 8'h00, 1'b0, 1'b1, 48'h0000_0000_0000};
    rows[1] = '{1'b1, 8'hFF, 48'hFFFF_FFFF_FFFF, 8'hAB, 1'b0, 1'b1, 48'hFFFF_FFFF_FFFF};
    rows[2] = '{1'b0, 8'h00, 48'h1234_5678_9ABC, 8'h55, 1'b1, 1'b0, 48'h0};

    repeat (3) @(negedge clk);
    rst_n <= 1'b1;

    foreach (rows[r]) begin
      if (rows[r].has_lead) send_byte(rows[r].lead, 1'b0, '0);
      f = build_frame(rows[r].dists, rows[r].fill, 1'b0, rows[r].corrupt);
      send_frame(f, FRAME_LEN, rows[r].typed, rows[r].want);
    end
    drain();

    while (bytes_sent < 1900) begin
      if (bytes_sent >= 1600) idle_en = 1'b0;
      if (!held && bytes_sent >= 600) begin
        held = 1'b1;
        hold_req = 1'b1;
      end
      if (!paused && bytes_sent >= 1100) begin
        paused = 1'b1;
        drain();
      end
      tx_idle_pct = ($urandom_range(0, 3) == 0) ? 0 : 12;
      d.first_distance = pick_distance();
      d.peak_distance  = pick_distance();
      d.last_distance  = pick_distance();
      kind = $urandom_range(0, 99);
      if (kind < 70) begin
        send_frame(build_frame(d, 8'h00, 1'b1, 1'b0), FRAME_LEN, 1'b0, '0);
      end else if (kind < 80) begin
        send_frame(build_frame(d, 8'h00, 1'b1, 1'b1), FRAME_LEN, 1'b0, '0);
      end else if (kind < 88) begin
        n = $urandom_range(1, 4);
        repeat (n) send_byte(8'($urandom), 1'b0, '0);
      end else if (kind < 94) begin
        // A cut-short frame; the bytes that follow are absorbed into it.
        send_frame(build_frame(d, 8'h00, 1'b1, 1'b0), $urandom_range(1, FRAME_LEN - 1),
                   1'b0, '0);
      end else begin
        n = $urandom_range(1, 20);
        repeat (n) send_byte(8'($urandom), 1'b0, '0);
      end
    end

    @(negedge clk);
    in_valid <= 1'b0;
    while (pending_dists.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (errors == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
+incdir+hw/rtl
hw/rtl/rfxp_pkg.sv
hw/rtl/rfxp_frame.sv
hw/rtl/range_frame_xor_parser.sv
bench/tb.sv
